// ----- sv/filtered_stop_detector_macros.svh -----
// Assertion macros used by the port checker
`ifndef FILTERED_STOP_DETECTOR_MACROS_SVH
`define FILTERED_STOP_DETECTOR_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define FSD_ASSERT_SAME(label, clk, trig, cond, msg) \
  label: assert property (@(posedge clk) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger
`define FSD_ASSERT_NEXT(label, clk, trig, cond, msg) \
  label: assert property (@(posedge clk) (trig) |=> (cond)) else $error(msg);

`endif

// ----- sv/fsd_pkg.sv -----
// Types, constants and codes of the filtered stop detector
`default_nettype none
package fsd_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;

  localparam int unsigned NUM_AXES  = 6;
  localparam int unsigned AXIS_W    = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned ACC_W     = 58;
  localparam int unsigned IN_SHIFT  = 12;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned SUM_W     = 64;

  localparam logic [AXIS_W-1:0] AXIS_FIRST_VEL  = 3'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAST_VEL   = 3'd2;
  localparam logic [AXIS_W-1:0] AXIS_FIRST_RATE = 3'd3;
  localparam logic [AXIS_W-1:0] AXIS_LAST       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_VEL_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP     = 3'd4;

  localparam logic signed [MUL_W-1:0] COEF_B = 33'sd52542;
  localparam logic signed [MUL_W-1:0] COEF_A = 33'sd16672131;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = 58'sd8388608;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_IN,
    MUL_STATE,
    MUL_SQUARE
  } mul_sel_t;

  typedef struct packed {
    logic [7:0]         confidence;
    logic [7:0]         mode_request;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0] mode_effective;
    logic       stopped;
    logic       vel_quiet;
    logic       rate_quiet;
  } out_word_t;

  typedef struct packed {
    logic              start;
    mul_sel_t          mul_sel;
    logic [AXIS_W-1:0] axis;
    logic              acc_load;
    logic              upd;
    logic              sum_add;
    logic              sum_clr;
    logic              cmp_vel;
    logic              finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/fsd_ctrl.sv -----
// Sequencer that steps the shared multiplier through the six axes
`default_nettype none
module fsd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fsd_pkg::dp_sts_t sts,
  output fsd_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_S,
    ST_UPD,
    ST_MUL_Q,
    ST_SUM_V,
    ST_SUM_R,
    ST_FIN
  } state_t;

  state_t                     state_r, state_nxt;
  logic [fsd_pkg::AXIS_W-1:0] axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= fsd_pkg::AXIS_FIRST_VEL;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    cmd          = '0;
    cmd.mul_sel  = fsd_pkg::MUL_NONE;
    cmd.axis     = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.sum_clr = 1'b1;
          axis_nxt    = fsd_pkg::AXIS_FIRST_VEL;
          state_nxt   = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.mul_sel = fsd_pkg::MUL_IN;
        cmd.sum_add = (axis_r != fsd_pkg::AXIS_FIRST_VEL) &&
                      (axis_r != fsd_pkg::AXIS_FIRST_RATE);
        cmd.cmp_vel = (axis_r == fsd_pkg::AXIS_FIRST_RATE);
        cmd.sum_clr = (axis_r == fsd_pkg::AXIS_FIRST_RATE);
        state_nxt   = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_sel  = fsd_pkg::MUL_STATE;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        cmd.mul_sel = fsd_pkg::MUL_SQUARE;
        if (axis_r == fsd_pkg::AXIS_LAST_VEL) begin
          state_nxt = ST_SUM_V;
        end else if (axis_r == fsd_pkg::AXIS_LAST) begin
          state_nxt = ST_SUM_R;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_MUL_X;
        end
      end
      ST_SUM_V: begin
        cmd.sum_add = 1'b1;
        axis_nxt    = fsd_pkg::AXIS_FIRST_RATE;
        state_nxt   = ST_MUL_X;
      end
      ST_SUM_R: begin
        cmd.sum_add = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/fsd_dp.sv -----
// Datapath: config registers, filter states, shared multiplier, energy, history
`default_nettype none
module fsd_dp #(
  parameter int unsigned HISTORY_DEPTH = fsd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fsd_pkg::dp_cmd_t              cmd,
  output fsd_pkg::dp_sts_t                   sts,
  input  wire fsd_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fsd_pkg::out_word_t                 out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned MW = fsd_pkg::MUL_W;
  localparam int unsigned AW = fsd_pkg::ACC_W;
  localparam int unsigned FW = fsd_pkg::FRAC_W;
  localparam int unsigned SW = fsd_pkg::SUM_W;

  logic [31:0] vel_thr_r, rate_thr_r;
  logic [7:0]  conv_r, idle_r, stop_r;

  fsd_pkg::in_word_t  in_r;
  logic [7:0]         mode_r;
  logic signed [31:0] filt_r [fsd_pkg::NUM_AXES];
  logic [7:0]         hist_r [HISTORY_DEPTH];

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic signed [2*MW-1:0] prod_r;
  logic signed [AW-1:0]   acc_r;
  logic [MW-1:0]          mag_r;
  logic                   sqhi_r;
  logic [SW-1:0]          sum_r;
  logic                   vel_quiet_r;

  fsd_pkg::out_word_t out_r;
  logic               out_valid_r;

  logic signed [15:0] x_sel;
  logic signed [31:0] old_sel;
  logic signed [AW-1:0] total;
  logic signed [31:0] new_val;
  logic signed [32:0] out_val;
  logic [MW-1:0]      mag;
  logic [SW:0]        sq;
  logic [SW:0]        sum_ext;
  logic [SW-1:0]      sum_sat;
  logic               vel_below, rate_below, held;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_thr_r  <= '0;
      rate_thr_r <= '0;
      conv_r     <= '0;
      idle_r     <= '0;
      stop_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fsd_pkg::CFG_VEL_THR:  vel_thr_r  <= cfg_wdata;
        fsd_pkg::CFG_RATE_THR: rate_thr_r <= cfg_wdata;
        fsd_pkg::CFG_CONV:     conv_r     <= cfg_wdata[7:0];
        fsd_pkg::CFG_IDLE:     idle_r     <= cfg_wdata[7:0];
        fsd_pkg::CFG_STOP:     stop_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.axis)
      3'd0:    x_sel = in_r.vel_x;
      3'd1:    x_sel = in_r.vel_y;
      3'd2:    x_sel = in_r.vel_z;
      3'd3:    x_sel = in_r.rate_x;
      3'd4:    x_sel = in_r.rate_y;
      3'd5:    x_sel = in_r.rate_z;
      default: x_sel = '0;
    endcase
  end

  assign old_sel = filt_r[cmd.axis];

  always_comb begin
    case (cmd.mul_sel)
      fsd_pkg::MUL_IN: begin
        mul_a = {{(MW-16){x_sel[15]}}, x_sel};
        mul_b = fsd_pkg::COEF_B;
      end
      fsd_pkg::MUL_STATE: begin
        mul_a = {old_sel[31], old_sel};
        mul_b = fsd_pkg::COEF_A;
      end
      fsd_pkg::MUL_SQUARE: begin
        mul_a = {1'b0, mag_r[31:0]};
        mul_b = {1'b0, mag_r[31:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // state update: round, saturate, sum with old state, magnitude
  assign total   = acc_r + $signed(prod_r[AW-1:0]);
  assign new_val = ((total[AW-1:AW-3] == 3'b000) || (total[AW-1:AW-3] == 3'b111))
                   ? total[FW+31:FW]
                   : (total[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign out_val = {new_val[31], new_val} + {old_sel[31], old_sel};
  assign mag     = out_val[32] ? (33'd0 - out_val) : out_val;

  // saturating energy sum
  assign sq      = sqhi_r ? {1'b1, {SW{1'b0}}} : {1'b0, prod_r[SW-1:0]};
  assign sum_ext = {1'b0, sum_r} + sq;
  assign sum_sat = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];

  assign vel_below  = (sum_r[SW-1:FW+32] == '0) && (sum_r[FW+31:FW] < vel_thr_r);
  assign rate_below = (sum_r[SW-1:FW+32] == '0) && (sum_r[FW+31:FW] < rate_thr_r);

  always_comb begin
    held = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_r[i] != stop_r) begin
        held = 1'b0;
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      in_r   <= in_data;
      mode_r <= (in_data.confidence == conv_r) ? in_data.mode_request : idle_r;
    end
    if (cmd.mul_sel != fsd_pkg::MUL_NONE) begin
      prod_r <= prod;
    end
    if (cmd.mul_sel == fsd_pkg::MUL_SQUARE) begin
      sqhi_r <= mag_r[MW-1];
    end
    if (cmd.acc_load) begin
      acc_r <= ($signed(prod_r[AW-1:0]) <<< fsd_pkg::IN_SHIFT) + fsd_pkg::ACC_ROUND;
    end
    if (cmd.upd) begin
      mag_r <= mag;
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_sat;
    end
    if (cmd.cmp_vel) begin
      vel_quiet_r <= vel_below;
    end
    if (cmd.finish) begin
      out_r.mode_effective <= mode_r;
      out_r.stopped        <= vel_quiet_r && rate_below && held;
      out_r.vel_quiet      <= vel_quiet_r;
      out_r.rate_quiet     <= rate_below;
    end
  end

  // filter states and mode history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsd_pkg::NUM_AXES; i++) begin
        filt_r[i] <= '0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cmd.upd) begin
        filt_r[cmd.axis] <= new_val;
      end
      if (cmd.finish) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

// ----- sv/filtered_stop_detector.sv -----
// Input words are accepted only while the sequencer is idle, one word at a time.
// One shared 33x33 multiplier runs four steps per axis over six axes, plus
// two energy sum steps and one result step.
// The result register lets the next word enter while a result waits.
// Reset (synchronous, active low) clears config, filter states, mode history
// and the output valid.
`default_nettype none
module filtered_stop_detector #(
  parameter int unsigned HISTORY_DEPTH = fsd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fsd_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fsd_pkg::out_word_t                 out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsd_pkg::CFG_W-1:0]     cfg_wdata
);

  fsd_pkg::dp_cmd_t cmd;
  fsd_pkg::dp_sts_t sts;

  fsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

// ----- sv/fsd_checker.sv -----
// Port checker for the filtered stop detector and its bind
`default_nettype none
`include "filtered_stop_detector_macros.svh"
module fsd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fsd_pkg::out_word_t out_data
);

  `FSD_ASSERT_NEXT(a_out_hold, clk, rst_n && out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `FSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n && in_valid && in_ready, !in_ready, "input accepted again right after accept")
  `FSD_ASSERT_SAME(a_stopped_quiet, clk, rst_n && out_valid && out_data.stopped, out_data.vel_quiet && out_data.rate_quiet, "stopped without both vectors quiet")
  `FSD_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind filtered_stop_detector fsd_checker u_fsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
